@@ hw/rtl/lasc_pkg.sv @@
// Shared constants, types and microcode table for the LFU attribute slot cache.
`default_nettype none

package lasc_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PC_W   = 4;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // micro-operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LATCH = 3'd1;
    localparam logic [2:0] OP_INIT  = 3'd2;
    localparam logic [2:0] OP_SCAN  = 3'd3;
    localparam logic [2:0] OP_BUMP  = 3'd4;
    localparam logic [2:0] OP_REPL  = 3'd5;
    localparam logic [2:0] OP_EMIT  = 3'd6;

    // slot memory read address select
    localparam logic [2:0] RS_NONE  = 3'd0;
    localparam logic [2:0] RS_CUR   = 3'd1;
    localparam logic [2:0] RS_IDX   = 3'd2;
    localparam logic [2:0] RS_IDXP1 = 3'd3;
    localparam logic [2:0] RS_K     = 3'd4;
    localparam logic [2:0] RS_J     = 3'd5;

    // jump conditions
    localparam logic [2:0] C_NEVER  = 3'd0;
    localparam logic [2:0] C_ALWAYS = 3'd1;
    localparam logic [2:0] C_INVLD  = 3'd2;
    localparam logic [2:0] C_BYPASS = 3'd3;
    localparam logic [2:0] C_CURHIT = 3'd4;
    localparam logic [2:0] C_LAST   = 3'd5;
    localparam logic [2:0] C_FOUND  = 3'd6;
    localparam logic [2:0] C_OFREE  = 3'd7;

    // result outcome codes
    localparam logic [2:0] OC_CUR   = 3'd0;
    localparam logic [2:0] OC_OTHER = 3'd1;
    localparam logic [2:0] OC_REPL  = 3'd2;
    localparam logic [2:0] OC_BAD   = 3'd3;
    localparam logic [2:0] OC_BUF   = 3'd4;

    // program addresses
    localparam logic [PC_W-1:0] PC_WAIT   = 4'd0;
    localparam logic [PC_W-1:0] PC_CHKBYP = 4'd1;
    localparam logic [PC_W-1:0] PC_CHKCUR = 4'd2;
    localparam logic [PC_W-1:0] PC_RD0    = 4'd3;
    localparam logic [PC_W-1:0] PC_SCAN   = 4'd4;
    localparam logic [PC_W-1:0] PC_DECIDE = 4'd5;
    localparam logic [PC_W-1:0] PC_RDJ    = 4'd6;
    localparam logic [PC_W-1:0] PC_REPL   = 4'd7;
    localparam logic [PC_W-1:0] PC_RDK    = 4'd8;
    localparam logic [PC_W-1:0] PC_BUMPK  = 4'd9;
    localparam logic [PC_W-1:0] PC_BUMPC  = 4'd10;
    localparam logic [PC_W-1:0] PC_RDOUT  = 4'd11;
    localparam logic [PC_W-1:0] PC_EMIT   = 4'd12;

    typedef struct packed {
        logic [7:0] color;
        logic       etype;
        logic [7:0] tile;
        logic [2:0] mode;
    } key_t;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] rsel;
        logic [2:0] oc;
    } lasc_ctl_t;

    typedef struct packed {
        logic in_valid;
        logic bypass;
        logic cur_hit;
        logic last;
        logic found;
        logic out_free;
    } lasc_stat_t;

    typedef struct packed {
        lasc_ctl_t       ctl;
        logic [2:0]      cond;
        logic            hold;
        logic [PC_W-1:0] tgt;
    } uword_t;

    function automatic uword_t mk(input logic [2:0] op, input logic [2:0] rsel,
                                  input logic [2:0] oc, input logic [2:0] cond,
                                  input logic hold, input logic [PC_W-1:0] tgt);
        uword_t w;
        w.ctl.op   = op;
        w.ctl.rsel = rsel;
        w.ctl.oc   = oc;
        w.cond     = cond;
        w.hold     = hold;
        w.tgt      = tgt;
        return w;
    endfunction

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_WAIT:   w = mk(OP_LATCH, RS_NONE,  OC_CUR,   C_INVLD,  1'b1, PC_CHKBYP);
            PC_CHKBYP: w = mk(OP_NOP,   RS_CUR,   OC_CUR,   C_BYPASS, 1'b0, PC_RDOUT);
            PC_CHKCUR: w = mk(OP_INIT,  RS_NONE,  OC_CUR,   C_CURHIT, 1'b0, PC_BUMPC);
            PC_RD0:    w = mk(OP_NOP,   RS_IDX,   OC_CUR,   C_NEVER,  1'b0, PC_WAIT);
            PC_SCAN:   w = mk(OP_SCAN,  RS_IDXP1, OC_CUR,   C_LAST,   1'b1, PC_DECIDE);
            PC_DECIDE: w = mk(OP_NOP,   RS_NONE,  OC_CUR,   C_FOUND,  1'b0, PC_RDK);
            PC_RDJ:    w = mk(OP_NOP,   RS_J,     OC_CUR,   C_NEVER,  1'b0, PC_WAIT);
            PC_REPL:   w = mk(OP_REPL,  RS_NONE,  OC_REPL,  C_ALWAYS, 1'b0, PC_RDOUT);
            PC_RDK:    w = mk(OP_NOP,   RS_K,     OC_CUR,   C_NEVER,  1'b0, PC_WAIT);
            PC_BUMPK:  w = mk(OP_BUMP,  RS_NONE,  OC_OTHER, C_ALWAYS, 1'b0, PC_RDOUT);
            PC_BUMPC:  w = mk(OP_BUMP,  RS_NONE,  OC_CUR,   C_NEVER,  1'b0, PC_WAIT);
            PC_RDOUT:  w = mk(OP_NOP,   RS_CUR,   OC_CUR,   C_NEVER,  1'b0, PC_WAIT);
            PC_EMIT:   w = mk(OP_EMIT,  RS_NONE,  OC_CUR,   C_OFREE,  1'b1, PC_WAIT);
            default:   w = mk(OP_NOP,   RS_NONE,  OC_CUR,   C_ALWAYS, 1'b0, PC_WAIT);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lasc_if.sv @@
// Request and result channel interfaces.
`default_nettype none

interface lasc_req_if;
    logic              valid;
    logic              ready;
    logic [7:0]        color;
    logic              edge_type;
    logic signed [8:0] tile;
    logic [2:0]        draw_mode;
    logic              color_defined;
    logic              tile_defined;
    logic              buffer_active;

    modport source (
        output valid, color, edge_type, tile, draw_mode,
               color_defined, tile_defined, buffer_active,
        input  ready
    );
    modport sink (
        input  valid, color, edge_type, tile, draw_mode,
               color_defined, tile_defined, buffer_active,
        output ready
    );
endinterface

interface lasc_rsp_if;
    logic              valid;
    logic              ready;
    logic [3:0]        slot_number;
    logic [2:0]        outcome;
    logic              tile_warning;
    logic [3:0]        change_mask;
    logic [7:0]        current_color;
    logic              current_type;
    logic signed [8:0] current_tile;
    logic [2:0]        current_mode;

    modport source (
        output valid, slot_number, outcome, tile_warning, change_mask,
               current_color, current_type, current_tile, current_mode,
        input  ready
    );
    modport sink (
        input  valid, slot_number, outcome, tile_warning, change_mask,
               current_color, current_type, current_tile, current_mode,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/lasc_useq.sv @@
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module lasc_useq
    import lasc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lasc_stat_t stat,
    output lasc_ctl_t       ctl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            take;

    assign uw  = ucode(pc_reg);
    assign ctl = uw.ctl;

    always_comb
    begin
        case (uw.cond)
            C_NEVER:  take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_INVLD:  take = stat.in_valid;
            C_BYPASS: take = stat.bypass;
            C_CURHIT: take = stat.cur_hit;
            C_LAST:   take = stat.last;
            C_FOUND:  take = stat.found;
            C_OFREE:  take = stat.out_free;
            default:  take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            pc_next = uw.tgt;
        end
        else if (uw.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lasc_dpath.sv @@
// Datapath: request registers, slot memory, scan compare, result register.
`default_nettype none

module lasc_dpath
    import lasc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire lasc_ctl_t ctl,
    input  wire logic      tile_one_defined,
    output lasc_stat_t     stat,
    lasc_req_if.sink       req,
    lasc_rsp_if.source     rsp
);

    key_t              key_mem [SLOTS];
    logic [31:0]       cnt_mem [SLOTS];
    logic [SLOTS-1:0]  vld_reg;

    key_t              rd_key_reg;
    logic [31:0]       rd_cnt_reg;
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] rd_addr_reg;

    logic [7:0]        color_reg;
    logic              etype_reg;
    logic [7:0]        tile_reg;
    logic [2:0]        mode_reg;
    logic              warn_reg;
    logic              pat_reg;
    logic [2:0]        oc_reg;
    logic [3:0]        mask_reg;
    logic [3:0]        mask_next;

    logic [SLOT_W-1:0] cur_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] j_reg;
    logic [SLOT_W-1:0] k_reg;
    logic              found_reg;
    logic [31:0]       best_reg;

    logic              ovld_reg;
    logic [3:0]        onum_reg;
    logic [2:0]        ooc_reg;
    logic              owarn_reg;
    logic [3:0]        omask_reg;
    logic [7:0]        ocolor_reg;
    logic              otype_reg;
    logic signed [8:0] otile_reg;
    logic [2:0]        omode_reg;

    logic [SLOT_W-1:0] rd_addr;
    logic              rd_en;
    key_t              eff_key;
    logic [31:0]       eff_cnt;
    key_t              req_key;
    key_t              new_key;
    logic              match;
    logic              fire;
    logic              out_free;
    logic [7:0]        tile_n;
    logic              warn_n;
    logic              pat_n;
    logic [31:0]       cnt_next;
    logic [7:0]        num_ext;
    logic [3:0]        num;
    logic signed [8:0] rtile;

    assign fire     = req.valid && req.ready;
    assign out_free = !ovld_reg || rsp.ready;
    assign req.ready = (ctl.op == OP_LATCH);

    assign eff_key = rd_vld_reg ? rd_key_reg : '0;
    assign eff_cnt = rd_vld_reg ? rd_cnt_reg : 32'd0;
    assign req_key = '{color: color_reg, etype: etype_reg, tile: tile_reg, mode: mode_reg};
    assign match   = (eff_key == req_key);

    assign stat.in_valid = req.valid;
    assign stat.bypass   = (oc_reg == OC_BUF) || (oc_reg == OC_BAD);
    assign stat.cur_hit  = match;
    assign stat.last     = (idx_reg == SLOT_W'(SLOTS - 1));
    assign stat.found    = found_reg;
    assign stat.out_free = out_free;

    // normalize the requested tile
    always_comb
    begin
        tile_n = 8'd1;
        warn_n = 1'b0;
        pat_n  = tile_one_defined;
        if (req.tile[8])
        begin
            tile_n = 8'd0;
            pat_n  = 1'b0;
        end
        else if (req.tile == 9'sd0)
        begin
            tile_n = 8'd1;
        end
        else if (!req.tile_defined)
        begin
            warn_n = 1'b1;
        end
        else
        begin
            tile_n = req.tile[7:0];
            pat_n  = 1'b1;
        end
    end

    always_comb
    begin
        case (ctl.rsel)
            RS_CUR:   rd_addr = cur_reg;
            RS_IDX:   rd_addr = idx_reg;
            RS_IDXP1: rd_addr = idx_reg + SLOT_W'(1);
            RS_K:     rd_addr = k_reg;
            RS_J:     rd_addr = j_reg;
            default:  rd_addr = cur_reg;
        endcase
    end
    assign rd_en = (ctl.rsel != RS_NONE);

    assign cnt_next = (eff_cnt == CNT_MAX) ? eff_cnt : eff_cnt + 32'd1;
    assign new_key  = req_key;

    always_comb
    begin
        mask_next = 4'd0;
        if (mode_reg != eff_key.mode)
        begin
            mask_next[0] = 1'b1;
        end
        else if (color_reg != eff_key.color)
        begin
            mask_next[1] = 1'b1;
        end
        if (tile_reg != eff_key.tile)
        begin
            mask_next[2] = 1'b1;
            mask_next[3] = (tile_reg != 8'd0) && pat_reg;
        end
    end

    assign num_ext = 8'(cur_reg) + 8'd1;
    assign num     = num_ext[3:0];
    assign rtile   = (eff_key.tile > 8'd1) ? $signed({1'b0, eff_key.tile})
                                           : $signed({1'b0, eff_key.tile} - 9'd1);

    // slot memory: one read, one write port
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_REPL)
        begin
            key_mem[rd_addr_reg] <= new_key;
            cnt_mem[rd_addr_reg] <= 32'd1;
        end
        else if (ctl.op == OP_BUMP)
        begin
            key_mem[rd_addr_reg] <= eff_key;
            cnt_mem[rd_addr_reg] <= cnt_next;
        end
        if (rd_en)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_cnt_reg  <= cnt_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // request and scan payload
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LATCH && fire)
        begin
            color_reg <= req.color;
            etype_reg <= req.edge_type;
            tile_reg  <= tile_n;
            mode_reg  <= req.draw_mode;
            pat_reg   <= pat_n;
        end
        if (ctl.op == OP_INIT)
        begin
            idx_reg  <= '0;
            j_reg    <= '0;
            best_reg <= CNT_MAX;
        end
        if (ctl.op == OP_SCAN)
        begin
            idx_reg <= idx_reg + SLOT_W'(1);
            if (match)
            begin
                k_reg <= idx_reg;
            end
            if (eff_cnt < best_reg)
            begin
                j_reg    <= idx_reg;
                best_reg <= eff_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            cur_reg   <= '0;
            oc_reg    <= OC_CUR;
            warn_reg  <= 1'b0;
            mask_reg  <= 4'd0;
            found_reg <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            case (ctl.op)
                OP_LATCH:
                begin
                    if (fire)
                    begin
                        mask_reg <= 4'd0;
                        if (req.buffer_active)
                        begin
                            oc_reg   <= OC_BUF;
                            warn_reg <= 1'b0;
                        end
                        else if (!req.color_defined)
                        begin
                            oc_reg   <= OC_BAD;
                            warn_reg <= 1'b0;
                        end
                        else
                        begin
                            oc_reg   <= OC_REPL;
                            warn_reg <= warn_n;
                        end
                    end
                end
                OP_INIT:
                begin
                    found_reg <= 1'b0;
                end
                OP_SCAN:
                begin
                    if (match)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                OP_BUMP:
                begin
                    cur_reg              <= rd_addr_reg;
                    oc_reg               <= ctl.oc;
                    vld_reg[rd_addr_reg] <= 1'b1;
                end
                OP_REPL:
                begin
                    cur_reg              <= rd_addr_reg;
                    oc_reg               <= ctl.oc;
                    mask_reg             <= mask_next;
                    vld_reg[rd_addr_reg] <= 1'b1;
                end
                default:
                begin
                end
            endcase
            if (ctl.op == OP_EMIT && out_free)
            begin
                ovld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ovld_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_EMIT && out_free)
        begin
            case (oc_reg)
                OC_BUF:  onum_reg <= 4'd1;
                OC_BAD:  onum_reg <= 4'd0;
                default: onum_reg <= num;
            endcase
            ooc_reg    <= oc_reg;
            owarn_reg  <= warn_reg;
            omask_reg  <= mask_reg;
            ocolor_reg <= eff_key.color;
            otype_reg  <= eff_key.etype;
            otile_reg  <= rtile;
            omode_reg  <= eff_key.mode;
        end
    end

    assign rsp.valid         = ovld_reg;
    assign rsp.slot_number   = onum_reg;
    assign rsp.outcome       = ooc_reg;
    assign rsp.tile_warning  = owarn_reg;
    assign rsp.change_mask   = omask_reg;
    assign rsp.current_color = ocolor_reg;
    assign rsp.current_type  = otype_reg;
    assign rsp.current_tile  = otile_reg;
    assign rsp.current_mode  = omode_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lfu_attribute_slot_cache_top.sv @@
// Top level of the LFU attribute slot cache: config register, sequencer, datapath.
// One request at a time; the next beat can be taken in the cycle after the result is
// loaded. A miss on the slot in force scans all slots through the one read port.
// Reset clears the sequencer, slot valid bits (all slots read as zero) and current slot.
`default_nettype none

module lfu_attribute_slot_cache_top
    import lasc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lasc_req_if.sink   req,
    lasc_rsp_if.source rsp,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata
);

    logic       tod_reg;
    lasc_ctl_t  ctl;
    lasc_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tod_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            tod_reg <= cfg_wdata;
        end
    end

    lasc_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    lasc_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .tile_one_defined (tod_reg),
        .stat             (stat),
        .req              (req),
        .rsp              (rsp)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while previous one in flight");

    a_buf_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.outcome == OC_BUF |->
            rsp.slot_number == 4'd1 && rsp.change_mask == 4'd0 && !rsp.tile_warning)
        else $error("bad buffered result");

    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.outcome == OC_BAD |->
            rsp.slot_number == 4'd0 && rsp.change_mask == 4'd0 && !rsp.tile_warning)
        else $error("bad color result malformed");

    a_hit_mask: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.outcome == OC_CUR || rsp.outcome == OC_OTHER) |->
            rsp.change_mask == 4'd0 && rsp.slot_number != 4'd0)
        else $error("hit with change mask or no slot");

endmodule

`default_nettype wire

@@ sim/tb_lfu_attribute_slot_cache_top.sv @@
// Self-checking testbench for the LFU attribute slot cache top level.
`default_nettype none

module tb_lfu_attribute_slot_cache_top
    import lasc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = SLOTS + 16;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [7:0]        color;
        logic              edge_type;
        logic signed [8:0] tile;
        logic [2:0]        draw_mode;
        logic              color_defined;
        logic              tile_defined;
        logic              buffer_active;
    } request_t;

    typedef struct packed {
        logic [3:0]        slot_number;
        logic [2:0]        outcome;
        logic              tile_warning;
        logic [3:0]        change_mask;
        logic [7:0]        current_color;
        logic              current_type;
        logic signed [8:0] current_tile;
        logic [2:0]        current_mode;
    } result_t;

    class attribute_slot_scoreboard;
        key_t        slot_key[SLOTS];
        logic [31:0] use_count[SLOTS];
        int unsigned slot_in_force;
        bit          tile_one_defined;
        result_t     expected_choices[$];
        int          failures;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_key[i]  = '0;
                use_count[i] = '0;
            end
            slot_in_force    = 0;
            tile_one_defined = 1'b0;
            failures         = 0;
        endfunction

        function int pending();
            return expected_choices.size();
        endfunction

        function void bump(int unsigned s);
            if (use_count[s] != CNT_MAX)
                use_count[s] = use_count[s] + 32'd1;
        endfunction

        function result_t in_force(logic [3:0] num, logic [2:0] oc, logic warn,
                                   logic [3:0] mask);
            result_t    r;
            key_t       k;
            logic [8:0] wide;
            k = slot_key[slot_in_force];
            wide = {1'b0, k.tile};
            r.slot_number   = num;
            r.outcome       = oc;
            r.tile_warning  = warn;
            r.change_mask   = mask;
            r.current_color = k.color;
            r.current_type  = k.etype;
            r.current_tile  = (k.tile > 8'd1) ? wide : wide - 9'd1;
            r.current_mode  = k.mode;
            return r;
        endfunction

        function result_t predict_slot_choice(request_t r);
            key_t       want;
            logic       warn;
            logic       pattern;
            logic [3:0] mask;
            int         hit_idx;
            int         low_idx;
            if (r.buffer_active)
                return in_force(4'd1, OC_BUF, 1'b0, 4'd0);
            if (!r.color_defined)
                return in_force(4'd0, OC_BAD, 1'b0, 4'd0);
            warn = 1'b0;
            if (r.tile[8])
            begin
                want.tile = 8'd0;
                pattern   = 1'b0;
            end
            else if (r.tile == 9'sd0)
            begin
                want.tile = 8'd1;
                pattern   = tile_one_defined;
            end
            else if (!r.tile_defined)
            begin
                want.tile = 8'd1;
                warn      = 1'b1;
                pattern   = tile_one_defined;
            end
            else
            begin
                want.tile = r.tile[7:0];
                pattern   = 1'b1;
            end
            want.color = r.color;
            want.etype = r.edge_type;
            want.mode  = r.draw_mode;

            if (slot_key[slot_in_force] == want)
            begin
                bump(slot_in_force);
                return in_force(4'(slot_in_force + 1), OC_CUR, warn, 4'd0);
            end
            hit_idx = -1;
            low_idx = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_key[i] == want)
                    hit_idx = i;
                if (use_count[i] < use_count[low_idx])
                    low_idx = i;
            end
            if (hit_idx >= 0)
            begin
                slot_in_force = hit_idx;
                bump(slot_in_force);
                return in_force(4'(slot_in_force + 1), OC_OTHER, warn, 4'd0);
            end
            mask = 4'd0;
            if (want.mode != slot_key[low_idx].mode)
                mask[0] = 1'b1;
            else if (want.color != slot_key[low_idx].color)
                mask[1] = 1'b1;
            if (want.tile != slot_key[low_idx].tile)
            begin
                mask[2] = 1'b1;
                if (want.tile != 8'd0 && pattern)
                    mask[3] = 1'b1;
            end
            slot_in_force      = low_idx;
            use_count[low_idx] = 32'd1;
            slot_key[low_idx]  = want;
            return in_force(4'(slot_in_force + 1), OC_REPL, warn, mask);
        endfunction

        function void note_request(request_t r);
            expected_choices.push_back(predict_slot_choice(r));
        endfunction

        function string show(result_t r);
            return {$sformatf("slot=%0d outcome=%0d warn=%0b mask=%b ",
                              r.slot_number, r.outcome, r.tile_warning, r.change_mask),
                    $sformatf("color=%0d type=%0b tile=%0d mode=%0d",
                              r.current_color, r.current_type, $signed(r.current_tile),
                              r.current_mode)};
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_choices.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result beat: %s", show(got));
                return;
            end
            want = expected_choices.pop_front();
            if (got.slot_number   !== want.slot_number   ||
                got.outcome       !== want.outcome       ||
                got.tile_warning  !== want.tile_warning  ||
                got.change_mask   !== want.change_mask   ||
                got.current_color !== want.current_color ||
                got.current_type  !== want.current_type  ||
                got.current_tile  !== want.current_tile  ||
                got.current_mode  !== want.current_mode)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mismatch at %0t\n  expected %s\n  actual   %s",
                             $realtime, show(want), show(got));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    lasc_req_if req_ch();
    lasc_rsp_if rsp_ch();

    lfu_attribute_slot_cache_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    attribute_slot_scoreboard sb;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_off_len;
    int          hold_left;
    int          quiet_cycles;
    request_t    key_pool[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (rsp_ch.valid && rsp_ch.ready)
                    sb.check_result('{rsp_ch.slot_number, rsp_ch.outcome,
                                      rsp_ch.tile_warning, rsp_ch.change_mask,
                                      rsp_ch.current_color, rsp_ch.current_type,
                                      rsp_ch.current_tile, rsp_ch.current_mode});
                if (hold_off_len != 0)
                begin
                    hold_left    = hold_off_len;
                    hold_off_len = 0;
                end
                if (hold_left != 0)
                begin
                    hold_left--;
                    rsp_ch.ready <= 1'b0;
                end
                else
                    rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("lfu_attribute_slot_cache_top regression: fail");
                $finish;
            end
        end
    end

    function automatic request_t req_item(logic [7:0] color, logic etype, int tile,
                                          logic [2:0] mode, logic cdef, logic tdef,
                                          logic buffered);
        request_t r;
        r.color         = color;
        r.edge_type     = etype;
        r.tile          = 9'(tile);
        r.draw_mode     = mode;
        r.color_defined = cdef;
        r.tile_defined  = tdef;
        r.buffer_active = buffered;
        return r;
    endfunction

    function automatic request_t any_request();
        request_t r;
        r.color         = 8'($urandom);
        r.edge_type     = 1'($urandom);
        r.tile          = 9'($urandom);
        r.draw_mode     = 3'($urandom);
        r.color_defined = 1'($urandom);
        r.tile_defined  = 1'($urandom);
        r.buffer_active = 1'($urandom);
        return r;
    endfunction

    function automatic request_t well_formed_request();
        request_t r;
        r = any_request();
        r.color_defined = 1'b1;
        r.buffer_active = 1'b0;
        case ($urandom_range(3))
            0: r.tile = {1'b1, 8'($urandom)};
            1: r.tile = 9'sd0;
            2:
            begin
                r.tile         = 9'($urandom_range(1, 255));
                r.tile_defined = 1'b1;
            end
            default:
            begin
                r.tile         = 9'($urandom_range(1, 255));
                r.tile_defined = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input request_t item);
        bit idled;
        idled = 1'b0;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            if (!idled)
                req_ch.valid <= 1'b0;
            idled = 1'b1;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.color         <= item.color;
        req_ch.edge_type     <= item.edge_type;
        req_ch.tile          <= item.tile;
        req_ch.draw_mode     <= item.draw_mode;
        req_ch.color_defined <= item.color_defined;
        req_ch.tile_defined  <= item.tile_defined;
        req_ch.buffer_active <= item.buffer_active;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(item);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_tile_one(input bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.tile_one_defined = value;
    endtask

    task automatic run_random(input int count);
        request_t item;
        int       pick;
        key_pool.delete();
        repeat ($urandom_range(3, 14))
            key_pool.push_back(well_formed_request());
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                item = key_pool[$urandom_range(key_pool.size() - 1)];
            else if (pick < 78)
            begin
                item = any_request();
                item.buffer_active = 1'b1;
            end
            else if (pick < 86)
            begin
                item = well_formed_request();
                item.color_defined = 1'b0;
            end
            else
                item = any_request();
            send_request(item);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.color         = '0;
        req_ch.edge_type     = 1'b0;
        req_ch.tile          = '0;
        req_ch.draw_mode     = '0;
        req_ch.color_defined = 1'b0;
        req_ch.tile_defined  = 1'b0;
        req_ch.buffer_active = 1'b0;
        quiet_cycles         = 0;
        hold_off_len         = 0;
        tx_idle_pct          = 16;
        rx_idle_pct          = 70;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_tile_one(1'b0);
        send_request(req_item(8'd255, 1'b1, -256, 3'd7, 1'b0, 1'b1, 1'b1));
        send_request(req_item(8'd255, 1'b1, 255, 3'd7, 1'b0, 1'b1, 1'b0));
        send_request(req_item(8'd0, 1'b0, -1, 3'd0, 1'b1, 1'b0, 1'b0));
        send_request(req_item(8'd0, 1'b0, -256, 3'd0, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd255, 1'b1, 255, 3'd7, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd255, 1'b1, 0, 3'd7, 1'b1, 1'b0, 1'b0));
        send_request(req_item(8'd255, 1'b1, 5, 3'd7, 1'b1, 1'b0, 1'b0));
        send_request(req_item(8'd0, 1'b0, -5, 3'd0, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd0, 1'b1, -1, 3'd0, 1'b1, 1'b0, 1'b0));
        send_request(req_item(8'd7, 1'b0, 1, 3'd0, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd7, 1'b0, 1, 3'd3, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd100, 1'b0, 200, 3'd2, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd200, 1'b1, 2, 3'd4, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd1, 1'b0, 3, 3'd5, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd1, 1'b0, 128, 3'd1, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd2, 1'b1, -128, 3'd6, 1'b1, 1'b0, 1'b0));
        send_request(req_item(8'd255, 1'b1, 255, 3'd7, 1'b1, 1'b1, 1'b0));
        send_request(req_item(8'd128, 1'b0, 85, 3'd0, 1'b1, 1'b0, 1'b0));
        send_request(req_item(8'd0, 1'b0, -1, 3'd0, 1'b0, 1'b0, 1'b0));
        drain_results();

        write_tile_one(1'b1);
        send_request(req_item(8'd9, 1'b0, 0, 3'd1, 1'b1, 1'b0, 1'b0));
        send_request(req_item(8'd9, 1'b0, 77, 3'd1, 1'b1, 1'b0, 1'b0));
        send_request(req_item(8'd10, 1'b1, 40, 3'd6, 1'b1, 1'b0, 1'b0));
        send_request(req_item(8'd10, 1'b1, 40, 3'd6, 1'b0, 1'b1, 1'b1));
        run_random(330);
        drain_results();

        tx_idle_pct = 70;
        rx_idle_pct = 16;
        write_tile_one(1'b0);
        run_random(330);
        drain_results();

        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        write_tile_one(1'b1);
        hold_off_len = 600;
        run_random(340);
        drain_results();

        if (sb.failures == 0 && sb.pending() == 0)
            $display("lfu_attribute_slot_cache_top regression: pass");
        else
            $display("lfu_attribute_slot_cache_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
